// File: src/gma_pkg.sv
// Package for the grouped mean accumulator.
// Holds the shared sizes, the cell-to-cell record type and the config register indexes.
// No dependencies.
package gma_pkg;

    localparam int MAX_GROUPS_DEF = 64;
    localparam int MAX_ITEMS_DEF  = 1048576;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VAL_W   = 32;
    localparam int GRP_W   = 6;
    localparam int GCNT_W  = 7;
    localparam int SUM_W   = 52;
    localparam int CNT_W   = 21;
    localparam int MEAN_W  = 48;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SKIP_MISSING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT  = 1'd1;

    // One item as it travels along the row of group cells.
    typedef struct packed {
        logic              valid;
        logic              active;
        logic              missing;
        logic [GRP_W-1:0]  group;
        logic [VAL_W-1:0]  value;
    } gma_item_t;

    // Group contents handed to the divider.
    typedef struct packed {
        logic [GRP_W-1:0]        group;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic                    voided;
        logic                    last;
    } gma_grp_t;

endpackage

// File: src/gma_cell.sv
// One group cell: holds the sum, count and void mark of one group.
// Passes the item stream on to its neighbor; uses gma_pkg.
module gma_cell #(
    parameter int GROUP_ID  = 0,
    parameter int MAX_ITEMS = gma_pkg::MAX_ITEMS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gma_pkg::gma_item_t                item_in,
    input  logic                              clear,
    output gma_pkg::gma_item_t                item_out,
    output logic signed [gma_pkg::SUM_W-1:0]  sum,
    output logic [gma_pkg::CNT_W-1:0]         count,
    output logic                              voided
);
    import gma_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_ITEMS);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    void_reg, void_next;
    gma_item_t               item_reg;
    logic signed [SUM_W:0]   add;
    logic                    hit;

    assign hit = item_in.valid && item_in.active && item_in.group == GRP_W'(GROUP_ID);
    assign add = {sum_reg[SUM_W-1], sum_reg} +
                 (SUM_W+1)'(signed'(item_in.value));

    always_comb begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        void_next = void_reg;
        if (clear) begin
            sum_next  = '0;
            cnt_next  = '0;
            void_next = 1'b0;
        end else if (hit) begin
            if (cnt_reg < CNT_LIM) cnt_next = cnt_reg + 1'b1;
            if (item_in.missing) begin
                void_next = 1'b1;
            end else if (add[SUM_W] != add[SUM_W-1]) begin
                sum_next = add[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                sum_next = add[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            void_reg <= 1'b0;
            item_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            void_reg <= void_next;
            item_reg <= item_in;
        end
    end

    assign item_out = item_reg;
    assign sum      = sum_reg;
    assign count    = cnt_reg;
    assign voided   = void_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(clear) |-> cnt_reg == '0 && !void_reg)
        else $error("cell not cleared");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LIM)
        else $error("count above limit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(hit) && !$past(clear) |-> $stable(cnt_reg))
        else $error("count moved without item");

endmodule

// File: src/gma_div.sv
// Mean unit: restoring divider, one quotient bit per cycle, with rounding and saturation.
// Uses gma_pkg.
module gma_div #(
    parameter int FRAC_BITS = gma_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  gma_pkg::gma_grp_t                  grp,
    output logic                               busy,
    output logic                               done,
    output logic signed [gma_pkg::MEAN_W-1:0]  mean,
    output logic                               missing,
    output gma_pkg::gma_grp_t                  grp_out
);
    import gma_pkg::*;

    // numerator magnitude * 2^(F+1), quotient rounded as (q+1)>>1
    localparam int NUM_W  = SUM_W + FRAC_BITS + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'({1'b0, {(MEAN_W-1){1'b1}}});
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (MEAN_W-1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } st_t;

    st_t               st_reg, st_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    gma_grp_t          grp_reg, grp_next;
    logic [CNT_W:0]    trial;
    logic [SUM_W-1:0]  mag;
    logic [NUM_W-1:0]  rq, lim;

    assign mag   = grp.sum[SUM_W-1] ? SUM_W'(-grp.sum) : grp.sum;
    assign trial = {rem_reg[CNT_W-1:0], num_reg[NUM_W-1]} - {1'b0, grp_reg.count};
    assign rq    = (q_reg + 1'b1) >> 1;
    assign lim   = neg_reg ? NEG_LIM : POS_LIM;

    always_comb begin
        st_next   = st_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        grp_next  = grp_reg;
        case (st_reg)
            ST_IDLE: begin
                if (start) begin
                    grp_next  = grp;
                    neg_next  = grp.sum[SUM_W-1];
                    num_next  = {mag, {(FRAC_BITS+1){1'b0}}};
                    q_next    = '0;
                    rem_next  = '0;
                    step_next = STEP_W'(NUM_W);
                    if (grp.count == '0 || grp.voided) begin
                        done_next = 1'b1;
                    end else begin
                        st_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                num_next = num_reg << 1;
                if (!trial[CNT_W]) begin
                    rem_next = trial;
                    q_next   = {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[CNT_W-1:0], num_reg[NUM_W-1]};
                    q_next   = {q_reg[NUM_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    st_next   = ST_IDLE;
                    done_next = 1'b1;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        num_reg  <= num_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
        grp_reg  <= grp_next;
    end

    always_comb begin
        logic [NUM_W-1:0] m;
        m = (rq > lim) ? lim : rq;
        mean = neg_reg ? MEAN_W'(-m) : MEAN_W'(m);
        if (missing) mean = '0;
    end

    assign missing = grp_reg.count == '0 || grp_reg.voided;
    assign busy    = st_reg == ST_RUN || done_reg;
    assign done    = done_reg;
    assign grp_out = grp_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> st_reg == ST_IDLE)
        else $error("done while running");
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_RUN |-> grp_reg.count != '0)
        else $error("divide by zero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(st_reg == ST_RUN) || $past(start))
        else $error("done without work");

endmodule

// File: src/grouped_mean_accumulator_top.sv
// Grouped mean accumulator: a row of MAX_GROUPS group cells fed by a shifting item stream,
// and one bit-serial mean divider for the drain. Takes one sample per cycle while
// accumulating. A last sample starts a drain once it has passed the row; the groups are
// then divided one at a time, an empty or voided group skipping the divide, the receiver
// may hold off each result, and no sample is taken until the drain ends.
// Depends on gma_pkg, gma_cell and gma_div.
module grouped_mean_accumulator_top #(
    parameter int MAX_GROUPS = gma_pkg::MAX_GROUPS_DEF,
    parameter int MAX_ITEMS  = gma_pkg::MAX_ITEMS_DEF,
    parameter int FRAC_BITS  = gma_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gma_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sample_value[31:0], sample_missing[32], group_index[38:33], pad
    input  logic [39:0]                      s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_group[5:0], mean_value[53:6], mean_missing[54], sample_count[75:55], pad
    output logic [79:0]                      m_tdata,
    output logic                             m_tlast
);
    import gma_pkg::*;

    localparam int G_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    typedef enum logic [2:0] {
        ST_ACC   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_DRAIN = 3'b100
    } st_t;

    st_t               st_reg, st_next;
    logic              skip_reg;
    logic [GCNT_W-1:0] gcnt_reg;
    logic [GCNT_W-1:0] ng;
    logic [GCNT_W-1:0] fl_reg, fl_next;
    logic [GCNT_W-1:0] g_reg, g_next;
    logic              start;
    logic              clear;
    gma_item_t         chain [MAX_GROUPS+1];
    logic signed [SUM_W-1:0] sums [MAX_GROUPS];
    logic [CNT_W-1:0]  cnts [MAX_GROUPS];
    logic              voids [MAX_GROUPS];
    gma_grp_t          grp;
    logic              dv_busy, dv_done, dv_miss;
    logic signed [MEAN_W-1:0] dv_mean;
    gma_grp_t          dv_grp;
    logic              out_v_reg;
    logic [79:0]       out_d_reg;
    logic              out_l_reg;
    logic              acc;

    assign ng = (gcnt_reg > GCNT_W'(MAX_GROUPS)) ? GCNT_W'(MAX_GROUPS) : gcnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b1;
            gcnt_reg <= GCNT_W'(64);
        end else if (cfg_we) begin
            if (cfg_index == REG_SKIP_MISSING) skip_reg <= cfg_data[0];
            if (cfg_index == REG_GROUP_COUNT)  gcnt_reg <= cfg_data;
        end
    end

    assign s_tready = st_reg == ST_ACC;
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        chain[0].valid   = acc;
        chain[0].missing = s_tdata[32];
        chain[0].group   = s_tdata[38:33];
        chain[0].value   = s_tdata[31:0];
        chain[0].active  = {1'b0, s_tdata[38:33]} < ng && !(s_tdata[32] && skip_reg);
    end

    genvar i;
    generate
        for (i = 0; i < MAX_GROUPS; i++) begin : g_cell
            gma_cell #(.GROUP_ID(i), .MAX_ITEMS(MAX_ITEMS)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .item_in(chain[i]), .clear(clear),
                .item_out(chain[i+1]), .sum(sums[i]), .count(cnts[i]), .voided(voids[i])
            );
        end
    endgenerate

    always_comb begin
        grp.group  = GRP_W'(g_reg);
        grp.sum    = sums[g_reg[G_W-1:0]];
        grp.count  = cnts[g_reg[G_W-1:0]];
        grp.voided = voids[g_reg[G_W-1:0]];
        grp.last   = g_reg + 1'b1 == ng;
    end

    assign start = st_reg == ST_DRAIN && !dv_busy && !out_v_reg && g_reg < ng
                   && !(dv_done);

    always_comb begin
        st_next = st_reg;
        fl_next = fl_reg;
        g_next  = g_reg;
        clear   = 1'b0;
        case (st_reg)
            ST_ACC: begin
                if (acc && s_tlast) begin
                    st_next = ST_FLUSH;
                    fl_next = GCNT_W'(MAX_GROUPS);
                end
            end
            ST_FLUSH: begin
                fl_next = fl_reg - 1'b1;
                if (fl_reg == GCNT_W'(1)) begin
                    st_next = ST_DRAIN;
                    g_next  = '0;
                end
            end
            ST_DRAIN: begin
                if (start) g_next = g_reg + 1'b1;
                if (g_reg >= ng && !dv_busy && !out_v_reg) begin
                    clear   = 1'b1;
                    st_next = ST_ACC;
                end
            end
            default: st_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_ACC;
            fl_reg    <= '0;
            g_reg     <= '0;
            out_v_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            fl_reg <= fl_next;
            g_reg  <= g_next;
            if (dv_done) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
        if (dv_done) begin
            out_d_reg <= {4'b0, dv_grp.count, dv_miss, dv_mean, dv_grp.group};
            out_l_reg <= dv_grp.last;
        end
    end

    gma_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(start), .grp(grp),
        .busy(dv_busy), .done(dv_done), .mean(dv_mean), .missing(dv_miss),
        .grp_out(dv_grp)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tlast  = out_l_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_done |-> !out_v_reg || m_tready)
        else $error("result overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !out_v_reg && !dv_busy)
        else $error("accepting during drain");
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear |-> st_reg == ST_DRAIN)
        else $error("clear outside drain");

endmodule

// File: dv/gma_checker.sv
// Checker for the grouped mean accumulator: watches the sample and mean streams,
// predicts the per-group means and compares each mean item field by field.
// Depends on gma_pkg.
module gma_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [gma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gma_pkg::CFG_W-1:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_means
);
    import gma_pkg::*;

    localparam longint SUM_HI = 64'sd2251799813685247;
    localparam longint SUM_LO = -64'sd2251799813685248;
    localparam longint MEAN_POS = 64'sd140737488355327;
    localparam longint MEAN_NEG = 64'sd140737488355328;

    typedef struct packed {
        logic [GRP_W-1:0]  grp;
        logic [MEAN_W-1:0] mean;
        logic              miss;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } mean_item_t;

    logic              skip_mode;
    logic [GCNT_W-1:0] grp_limit;
    longint            sums [MAX_GROUPS_DEF];
    int                counts [MAX_GROUPS_DEF];
    bit                voided [MAX_GROUPS_DEF];
    mean_item_t        mean_q [$];
    int                fail_cnt = 0;

    assign pending_means = mean_q.size();
    assign fail_count    = fail_cnt;

    function automatic logic [MEAN_W-1:0] rounded_mean(longint sum, int n);
        logic            neg;
        longint unsigned mag, q, r, fr, res;
        neg = sum < 0;
        mag = neg ? -sum : sum;
        q = mag / n;
        r = mag % n;
        fr = ((r << (FRAC_BITS_DEF + 1)) + n) / (longint'(n) * 2);
        if (q > (MEAN_NEG >> FRAC_BITS_DEF)) res = MEAN_NEG;
        else res = (q << FRAC_BITS_DEF) + fr;
        if (neg) begin
            if (res > MEAN_NEG) res = MEAN_NEG;
            res = -res;
        end else if (res > MEAN_POS) begin
            res = MEAN_POS;
        end
        return res[MEAN_W-1:0];
    endfunction

    task automatic accumulate_sample(logic [39:0] d, logic fin);
        longint     val, s;
        logic       miss;
        int         g, ng;
        mean_item_t m;
        val = longint'($signed(d[31:0]));
        miss = d[32];
        g = d[38:33];
        ng = grp_limit > MAX_GROUPS_DEF ? MAX_GROUPS_DEF : grp_limit;
        if (g < ng && !(miss && skip_mode)) begin
            if (counts[g] < MAX_ITEMS_DEF) counts[g]++;
            if (miss) begin
                voided[g] = 1;
            end else begin
                s = sums[g] + val;
                if (s > SUM_HI) s = SUM_HI;
                if (s < SUM_LO) s = SUM_LO;
                sums[g] = s;
            end
        end
        if (fin) begin
            for (int i = 0; i < ng; i++) begin
                m.grp = GRP_W'(i);
                m.miss = counts[i] == 0 || voided[i];
                m.mean = m.miss ? '0 : rounded_mean(sums[i], counts[i]);
                m.cnt = CNT_W'(counts[i]);
                m.last = i + 1 == ng;
                mean_q.push_back(m);
            end
            for (int i = 0; i < MAX_GROUPS_DEF; i++) begin
                sums[i] = 0;
                counts[i] = 0;
                voided[i] = 0;
            end
        end
    endtask

    task automatic check_mean(mean_item_t got);
        mean_item_t exp;
        if (mean_q.size() == 0) begin
            $error("unexpected mean item group %0d", got.grp);
            fail_cnt++;
            return;
        end
        exp = mean_q.pop_front();
        if (got.grp !== exp.grp) begin
            $error("out_group exp %0d got %0d", exp.grp, got.grp);
            fail_cnt++;
        end
        if (got.mean !== exp.mean) begin
            $error("mean_value exp %h got %h", exp.mean, got.mean);
            fail_cnt++;
        end
        if (got.miss !== exp.miss) begin
            $error("mean_missing exp %0d got %0d", exp.miss, got.miss);
            fail_cnt++;
        end
        if (got.cnt !== exp.cnt) begin
            $error("sample_count exp %0d got %0d", exp.cnt, got.cnt);
            fail_cnt++;
        end
        if (got.last !== exp.last) begin
            $error("last_result exp %0d got %0d", exp.last, got.last);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        mean_item_t got;
        if (!aresetn) begin
            skip_mode <= 1'b1;
            grp_limit <= 7'd64;
            for (int i = 0; i < MAX_GROUPS_DEF; i++) begin
                sums[i] = 0;
                counts[i] = 0;
                voided[i] = 0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_SKIP_MISSING) skip_mode <= cfg_data[0];
                else if (cfg_index == REG_GROUP_COUNT) grp_limit <= cfg_data;
            end
            if (s_tvalid && s_tready) accumulate_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.grp = m_tdata[5:0];
                got.mean = m_tdata[53:6];
                got.miss = m_tdata[54];
                got.cnt = m_tdata[75:55];
                got.last = m_tlast;
                check_mean(got);
            end
        end
    end
endmodule

// File: dv/tb_grouped_mean_accumulator_top.sv
// Testbench top for the grouped mean accumulator: drives samples and config writes
// with random idling and stalls; gma_checker predicts and checks the means.
// Depends on gma_pkg, gma_checker and grouped_mean_accumulator_top.
module tb_grouped_mean_accumulator_top;
    import gma_pkg::*;

    localparam int HOLD_LEN = 600;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [79:0]          m_tdata;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending_means;
    int                   send_idle_pct;
    int                   stall_pct;
    int                   hold_cycles = 0;
    int                   hold_req = 0;
    int                   hold_ack = 0;
    int                   cur_groups;

    grouped_mean_accumulator_top u_top (.*);

    gma_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("status: fail");
        $finish;
    end

    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cycles <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= $urandom_range(99) >= stall_pct;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_GROUP_COUNT) cur_groups = val > 64 ? 64 : val;
    endtask

    // drive one item at the falling edge, hold until accepted; valid stays up afterward
    task automatic send_sample(logic [31:0] v, logic miss, logic [5:0] g, logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, g, miss, v};
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (pending_means != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_frame(int n);
        int gl;
        gl = cur_groups == 0 ? 1 : cur_groups;
        for (int i = 0; i < n; i++) begin
            send_sample(rand_value(), $urandom_range(9) == 0,
                        GRP_W'($urandom_range(9) == 0 ? $urandom_range(63)
                                                      : $urandom_range(gl - 1)),
                        i == n - 1);
        end
    endtask

    initial begin
        int sent;
        int n;
        aresetn = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        cur_groups = 64;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: extremes, missing in both modes, out-of-range group, over-range group count
        write_reg(REG_GROUP_COUNT, 7'd4);
        send_sample(32'h7fff_ffff, 0, 0, 0);
        send_sample(32'h8000_0000, 0, 1, 0);
        send_sample(32'h8000_0000, 0, 1, 0);
        send_sample(32'd7, 1, 2, 0);
        send_sample(32'd5, 0, 2, 0);
        send_sample(32'd9, 0, 63, 0);
        send_sample(32'hffff_fffd, 0, 3, 0);
        send_sample(32'd2, 0, 3, 1);
        drain_idle();
        write_reg(REG_SKIP_MISSING, 7'd0);
        send_sample(32'd1, 1, 0, 0);
        send_sample(32'd3, 0, 1, 0);
        send_sample(32'd4, 0, 1, 0);
        send_sample(32'd9, 0, 5, 1);
        drain_idle();
        write_reg(REG_GROUP_COUNT, 7'd1);
        for (int i = 0; i < 6; i++) send_sample(32'h7fff_ffff, 0, 0, 0);
        send_sample(32'h7fff_ffff, 1, 0, 1);
        drain_idle();
        write_reg(REG_GROUP_COUNT, 7'd127);
        send_sample(32'hffff_ffff, 0, 63, 1);
        drain_idle();
        write_reg(REG_GROUP_COUNT, 7'd0);
        send_sample(32'd5, 0, 0, 1);
        drain_idle();
        write_reg(REG_SKIP_MISSING, 7'd1);
        write_reg(REG_GROUP_COUNT, 7'd8);

        // pressure: long receiver hold while the sender keeps offering
        hold_req++;
        random_frame(5);
        random_frame(5);
        drain_idle();

        sent = 0;
        while (sent < 250) begin
            case ($urandom_range(3))
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            if ($urandom_range(3) == 0) begin
                drain_idle();
                write_reg(REG_SKIP_MISSING, CFG_W'($urandom_range(1)));
                write_reg(REG_GROUP_COUNT,
                          CFG_W'($urandom_range(4) == 0 ? 64 : $urandom_range(1, 12)));
            end
            n = 8 + $urandom_range(16);
            random_frame(n);
            sent += n;
        end
        drain_idle();
        if (fail_count == 0 && pending_means == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: grouped_mean_accumulator_top.f
src/gma_pkg.sv
src/gma_cell.sv
src/gma_div.sv
src/grouped_mean_accumulator_top.sv
dv/gma_checker.sv
dv/tb_grouped_mean_accumulator_top.sv
